FILE: rtl/crc16_response_deframer_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef CRC16_RESPONSE_DEFRAMER_DEFINES_SVH
`define CRC16_RESPONSE_DEFRAMER_DEFINES_SVH

// Clocked property with reset disable.
`define CRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Stalled word must keep its value.
`define CRD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	`CRD_ASSERT(lbl, (vld && !rdy) |=> $stable(sig), msg)

`endif

FILE: rtl/crd_pkg.sv
// Shared types, constants and CRC function for the response deframer.
package crd_pkg;

	localparam int BYTE_W       = 8;
	localparam int POS_W        = 9;
	localparam int CRC_W        = 16;
	localparam int DECODE_BYTES = 8;
	localparam int HEAD_IDX_W   = $clog2(DECODE_BYTES);
	localparam int RESCAN_DEPTH = 4;
	localparam int RESCAN_IDX_W = $clog2(RESCAN_DEPTH);
	localparam int CFG_IDX_W    = 1;
	localparam int KIND_W       = 2;
	localparam int OUT_DATA_W   = 136;

	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_HEADER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = 1'b1;

	localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'h3C;
	localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd60;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	localparam logic [BYTE_W-1:0] CMD_MEASURE_A  = 8'h2F;
	localparam logic [BYTE_W-1:0] CMD_MEASURE_LO = 8'h50;
	localparam logic [BYTE_W-1:0] CMD_MEASURE_HI = 8'h56;
	localparam logic [BYTE_W-1:0] CMD_STATUS_A   = 8'h40;
	localparam logic [BYTE_W-1:0] CMD_STATUS_B   = 8'h41;
	localparam logic [BYTE_W-1:0] LEN_MEASURE    = 8'd8;
	localparam logic [BYTE_W-1:0] LEN_STATUS     = 8'd5;

	localparam logic [KIND_W-1:0] KIND_RAW     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

	typedef struct packed {
		logic                    take;
		logic                    rescan;
		logic [RESCAN_IDX_W-1:0] idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic len_bad;
		logic at_crc_high;
		logic out_busy;
	} dp_status_t;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/crd_ctrl.sv
// Controller: input handshake and rescan sequencer.
module crd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  crd_pkg::dp_status_t status,
	output crd_pkg::ctrl_cmd_t  cmd
);
	import crd_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_RESCAN = 1'b1;

	logic                    state_q;
	logic [RESCAN_IDX_W-1:0] cnt_q;
	logic                    accept;

	assign s_axis_tready = (state_q == ST_IDLE) && !(status.at_crc_high && status.out_busy);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign cmd.take   = accept;
	assign cmd.rescan = (state_q == ST_RESCAN);
	assign cmd.idx    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && status.len_bad) begin
						state_q <= ST_RESCAN;
						cnt_q   <= '0;
					end
				end
				ST_RESCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == RESCAN_IDX_W'(RESCAN_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/crd_datapath.sv
// Datapath: frame fields, CRC, payload head, rescan buffer and output register.
module crd_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [crd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [crd_pkg::BYTE_W-1:0]            cfg_wdata,
	input  logic [crd_pkg::BYTE_W-1:0]            in_byte,
	input  crd_pkg::ctrl_cmd_t                    cmd,
	output crd_pkg::dp_status_t                   status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [crd_pkg::KIND_W-1:0]            out_kind,
	output logic [crd_pkg::OUT_DATA_W-1:0]        out_data
);
	import crd_pkg::*;

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] max_len_q;

	logic [POS_W-1:0]  pos_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] seq_q;
	logic [BYTE_W-1:0] addr_q;
	logic [BYTE_W-1:0] command_q;
	logic [BYTE_W-1:0] len_q;
	logic [BYTE_W-1:0] crc_low_q;
	logic [BYTE_W-1:0] head_q  [DECODE_BYTES];
	logic [BYTE_W-1:0] rbuf_q  [RESCAN_DEPTH];

	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [BYTE_W-1:0] seq_out_q;
	logic [BYTE_W-1:0] addr_out_q;
	logic [BYTE_W-1:0] cmd_out_q;
	logic [BYTE_W-1:0] len_out_q;
	logic [15:0]       round_q;
	logic signed [31:0] total_q;
	logic signed [15:0] speed_q;
	logic [39:0]       status_q;

	logic [BYTE_W-1:0] e_byte;
	logic              e_en;
	logic              early;
	logic [CRC_W-1:0]  crc_next;
	logic [POS_W-1:0]  pay_end;
	logic [POS_W-1:0]  pay_off;
	logic              at_len;
	logic              in_payload;
	logic              at_crc_low;
	logic              at_crc_high;
	logic              crc_ok;
	logic              emit;
	logic              is_measure;
	logic              is_status;

	assign early       = (pos_q < POS_W'(4));
	assign e_byte      = cmd.rescan ? rbuf_q[cmd.idx] : in_byte;
	assign e_en        = (cmd.take || cmd.rescan) && early;
	assign crc_next    = crc_feed(crc_q, e_byte);
	assign pay_end     = {1'b0, len_q} + POS_W'(5);
	assign pay_off     = pos_q - POS_W'(5);
	assign at_len      = (pos_q == POS_W'(4));
	assign in_payload  = !early && !at_len && (pos_q < pay_end);
	assign at_crc_low  = !early && !at_len && (pos_q == pay_end);
	assign at_crc_high = !early && !at_len && (pos_q == pay_end + POS_W'(1));
	assign crc_ok      = (crc_low_q == crc_q[7:0]) && (in_byte == crc_q[15:8]);
	assign emit        = cmd.take && at_crc_high && crc_ok;

	assign is_measure = ((command_q == CMD_MEASURE_A) ||
			(command_q inside {[CMD_MEASURE_LO:CMD_MEASURE_HI]})) && (len_q == LEN_MEASURE);
	assign is_status  = ((command_q == CMD_STATUS_A) || (command_q == CMD_STATUS_B)) &&
			(len_q == LEN_STATUS);

	assign status.len_bad     = at_len && (in_byte > max_len_q);
	assign status.at_crc_high = at_crc_high;
	assign status.out_busy    = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESPONSE_HEADER: header_q  <= cfg_wdata;
				REG_MAX_PAYLOAD_LEN: max_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			seq_q     <= '0;
			addr_q    <= '0;
			command_q <= '0;
			len_q     <= '0;
			crc_low_q <= '0;
		end else if (e_en) begin
			case (pos_q[1:0])
				2'd0: begin
					if (e_byte == header_q) begin
						crc_q <= crc_feed(CRC_INIT, e_byte);
						pos_q <= POS_W'(1);
					end
				end
				2'd1: begin
					seq_q <= e_byte;
					crc_q <= crc_next;
					pos_q <= POS_W'(2);
				end
				2'd2: begin
					addr_q <= e_byte;
					crc_q  <= crc_next;
					pos_q  <= POS_W'(3);
				end
				default: begin
					command_q <= e_byte;
					crc_q     <= crc_next;
					pos_q     <= POS_W'(4);
				end
			endcase
		end else if (cmd.take) begin
			if (at_len) begin
				if (status.len_bad) begin
					pos_q <= '0;
					crc_q <= CRC_INIT;
				end else begin
					len_q <= in_byte;
					crc_q <= crc_next;
					pos_q <= POS_W'(5);
				end
			end else if (in_payload) begin
				crc_q <= crc_next;
				pos_q <= pos_q + POS_W'(1);
			end else if (at_crc_low) begin
				crc_low_q <= in_byte;
				pos_q     <= pos_q + POS_W'(1);
			end else begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && at_len && status.len_bad) begin
			rbuf_q[0] <= seq_q;
			rbuf_q[1] <= addr_q;
			rbuf_q[2] <= command_q;
			rbuf_q[3] <= in_byte;
		end
		if (cmd.take && in_payload && (pay_off < POS_W'(DECODE_BYTES))) begin
			head_q[pay_off[HEAD_IDX_W-1:0]] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			seq_out_q  <= seq_q;
			addr_out_q <= addr_q;
			cmd_out_q  <= command_q;
			len_out_q  <= len_q;
			kind_q     <= KIND_RAW;
			round_q    <= '0;
			total_q    <= '0;
			speed_q    <= '0;
			status_q   <= '0;
			if (is_measure) begin
				kind_q  <= KIND_MEASURE;
				round_q <= {head_q[1], head_q[0]};
				total_q <= {head_q[5], head_q[4], head_q[3], head_q[2]};
				speed_q <= {head_q[7], head_q[6]};
			end else if (is_status) begin
				kind_q   <= KIND_STATUS;
				status_q <= {head_q[4], head_q[3], head_q[2], head_q[1], head_q[0]};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_data  = {status_q, speed_q, total_q, round_q,
			len_out_q, cmd_out_q, addr_out_q, seq_out_q};

endmodule

FILE: rtl/crc16_response_deframer.sv
// Top level of the CRC-16/MODBUS response deframer.
// Takes one received byte per cycle while s_axis_tready is high and hunts for
// the response header, then collects sequence, address, command, length,
// payload and a low-first CRC. A checked frame gives one output word; frame
// kind travels on tuser. A length byte above max_payload_len stalls the input
// while the rescan sequencer feeds the four buffered bytes back through the
// header hunt, one per cycle. The final CRC byte is held off only while the
// previous result still waits in the output register.
module crc16_response_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [crd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crd_pkg::BYTE_W-1:0]          cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] sequence_res, [15:8] responder address, [23:16] command,
	// [31:24] payload_len, [47:32] round_count, [79:48] multi-turn count,
	// [95:80] speed_tenth_rpm, [135:96] status_bytes
	output logic [crd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic [crd_pkg::KIND_W-1:0]          m_axis_tuser   // [1:0] frame_kind
);
	import crd_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	crd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	crd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_byte   (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: rtl/crc16_response_deframer_checker.sv
// Port checker for the response deframer and its bind.
`include "crc16_response_deframer_defines.svh"

module crc16_response_deframer_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [crd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input logic [crd_pkg::KIND_W-1:0]          m_axis_tuser
);
	import crd_pkg::*;

	`CRD_ASSERT(a_out_valid_holds, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output word dropped while stalled")
	`CRD_ASSERT_HOLD(a_out_data_holds, m_axis_tvalid, m_axis_tready, m_axis_tdata, "output word changed while stalled")
	`CRD_ASSERT(a_word_follows_byte, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready), "output word without a received byte")
	`CRD_ASSERT(a_measure_len, (m_axis_tvalid && (m_axis_tuser == KIND_MEASURE)) |-> (m_axis_tdata[31:24] == LEN_MEASURE), "measure word with wrong length")

endmodule

bind crc16_response_deframer crc16_response_deframer_checker u_checker (.*);
